@@ src/trg_pkg.sv @@
package trg_pkg;

    // command codes carried in s_tuser
    localparam int CMD_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_END  = 2'd2
    } trg_cmd_t;

    // min_rate after reset: 3000 steps/min / 60, Q16.8
    localparam int MIN_RATE_RESET = 12800;

    // control result of one tick
    typedef struct packed {
        logic active;  // tick updates state
        logic valid;   // rate update issued
        logic stop;    // flush ramp done
    } trg_tick_ctl_t;

endpackage

@@ src/trg_rate_update.sv @@
module trg_rate_update
    import trg_pkg::*;
#(
    parameter int RATE_BITS = 24,
    parameter int STEP_BITS = 32
) (
    input  logic                 loaded,
    input  logic                 force_pending,
    input  logic [RATE_BITS-1:0] cur_rate,
    input  logic [RATE_BITS-1:0] cruise_rate,
    input  logic [RATE_BITS-1:0] end_rate,
    input  logic [RATE_BITS-1:0] rate_step,
    input  logic [STEP_BITS-1:0] accel_end,
    input  logic [STEP_BITS-1:0] decel_start,
    input  logic [STEP_BITS-1:0] steps_done,
    input  logic                 axis_moving,
    input  logic                 pause_flag,
    input  logic                 flush_flag,
    input  logic [RATE_BITS-1:0] min_rate,
    output logic [RATE_BITS-1:0] next_rate,
    output logic [RATE_BITS-1:0] rate_out,
    output trg_tick_ctl_t        ctl
);

    logic                 active;
    logic                 stop;
    logic [RATE_BITS-1:0] half_step;
    logic [RATE_BITS:0]   one_half_step;
    logic [RATE_BITS-1:0] one_half_sat;
    logic                 above_one_half;
    logic [STEP_BITS:0]   accel_limit;
    logic                 in_accel;
    logic                 in_decel;
    logic [RATE_BITS:0]   accel_sum;
    logic [RATE_BITS-1:0] accel_rate;
    logic [RATE_BITS-1:0] decel_pre;
    logic [RATE_BITS-1:0] decel_rate;
    logic [RATE_BITS-1:0] rate_less_step;

    assign active = loaded && !pause_flag && axis_moving;

    // 0.5 and 1.5 times the rate step, halves truncated
    assign half_step      = rate_step >> 1;
    assign one_half_step  = {1'b0, rate_step} + {1'b0, half_step};
    assign one_half_sat   = one_half_step[RATE_BITS] ? '1 : one_half_step[RATE_BITS-1:0];
    assign above_one_half = {1'b0, cur_rate} > one_half_step;
    assign rate_less_step = cur_rate - rate_step;

    // phase of the move from the step count
    assign accel_limit = {1'b0, accel_end} + {{STEP_BITS{1'b0}}, 1'b1};
    assign in_accel    = {1'b0, steps_done} <= accel_limit;
    assign in_decel    = steps_done > decel_start;

    // accelerate, clamped to cruise
    assign accel_sum  = {1'b0, cur_rate} + {1'b0, rate_step};
    assign accel_rate = (accel_sum > {1'b0, cruise_rate}) ? cruise_rate
                                                          : accel_sum[RATE_BITS-1:0];

    // decelerate with floor, then raise to end rate
    assign decel_pre  = above_one_half ? rate_less_step : one_half_sat;
    assign decel_rate = (decel_pre < end_rate) ? end_rate : decel_pre;

    // pick the new rate
    always_comb begin
        next_rate = cur_rate;
        stop      = 1'b0;
        if (force_pending) begin
            next_rate = cur_rate;
        end else if (flush_flag) begin
            if (above_one_half) begin
                next_rate = rate_less_step;
            end else if (cur_rate == half_step) begin
                stop = 1'b1;
            end else begin
                next_rate = half_step;
            end
        end else if (in_accel) begin
            next_rate = accel_rate;
        end else if (in_decel) begin
            next_rate = decel_rate;
        end else begin
            next_rate = cruise_rate;
        end
    end

    assign ctl.active = active;
    assign ctl.stop   = active && stop;
    assign ctl.valid  = active && !stop;

    // issued rate, never below min_rate
    always_comb begin
        if (!ctl.valid) begin
            rate_out = '0;
        end else if (next_rate < min_rate) begin
            rate_out = min_rate;
        end else begin
            rate_out = next_rate;
        end
    end

endmodule

@@ src/trapezoid_rate_generator_top.sv @@
// m_tvalid rises once an accepted s_ word has passed the input register and then the
// result register
// throughput: one word per cycle while m_tready is high; the rate state is updated in the
// result stage, so each word sees the state left by the word before it
// reset: aresetn synchronous active low; clears move loaded, pending force and both
// stage valids, and sets min_rate to 12800 (50.0 steps/s in Q16.8)
module trapezoid_rate_generator_top
    import trg_pkg::*;
#(
    parameter int RATE_BITS = 24,
    parameter int STEP_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [RATE_BITS-1:0]   cfg_wdata,    // min_rate
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_rate, cruise_rate, end_rate, rate_step, accel_end_step,
    // decel_start_step, steps_done, axis_moving, pause_flag, flush_flag, zero fill
    input  logic [((4*RATE_BITS+3*STEP_BITS+3+7)/8)*8-1:0] s_tdata,
    input  logic [CMD_BITS-1:0]    s_tuser,      // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // rate_out, rate_valid, stop_axis, zero fill
    output logic [((RATE_BITS+2+7)/8)*8-1:0] m_tdata
);

    localparam int S_DATA_BITS = ((4*RATE_BITS+3*STEP_BITS+3+7)/8)*8;
    localparam int M_DATA_BITS = ((RATE_BITS+2+7)/8)*8;
    localparam int OFS_START   = 0;
    localparam int OFS_CRUISE  = RATE_BITS;
    localparam int OFS_END     = 2*RATE_BITS;
    localparam int OFS_STEP    = 3*RATE_BITS;
    localparam int OFS_ACCEL   = 4*RATE_BITS;
    localparam int OFS_DECEL   = 4*RATE_BITS+STEP_BITS;
    localparam int OFS_STEPS   = 4*RATE_BITS+2*STEP_BITS;
    localparam int OFS_MOVING  = 4*RATE_BITS+3*STEP_BITS;
    localparam int OFS_PAUSE   = OFS_MOVING+1;
    localparam int OFS_FLUSH   = OFS_MOVING+2;

    // configuration
    logic [RATE_BITS-1:0]   min_rate_reg;

    // input stage
    logic                   in_valid_reg;
    trg_cmd_t               in_cmd_reg;
    logic [S_DATA_BITS-1:0] in_data_reg;
    logic                   advance;

    // move state
    logic                   loaded_reg, loaded_next;
    logic                   force_reg, force_next;
    logic [RATE_BITS-1:0]   rate_reg, rate_next;
    logic [RATE_BITS-1:0]   cruise_reg, end_reg, step_reg;
    logic [STEP_BITS-1:0]   accel_reg, decel_reg;

    // result stage
    logic                   out_valid_reg;
    logic [RATE_BITS-1:0]   out_rate_reg, out_rate_next;
    logic                   out_flag_reg, out_flag_next;
    logic                   out_stop_reg, out_stop_next;

    logic [RATE_BITS-1:0]   upd_rate;
    logic [RATE_BITS-1:0]   upd_rate_out;
    trg_tick_ctl_t          upd_ctl;

    // min_rate register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rate_reg <= RATE_BITS'(MIN_RATE_RESET);
        end else if (cfg_we) begin
            min_rate_reg <= cfg_wdata;
        end
    end

    // handshake: input stage moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= trg_cmd_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    // rate update for a tick
    trg_rate_update #(
        .RATE_BITS (RATE_BITS),
        .STEP_BITS (STEP_BITS)
    ) u_update (
        .loaded        (loaded_reg),
        .force_pending (force_reg),
        .cur_rate      (rate_reg),
        .cruise_rate   (cruise_reg),
        .end_rate      (end_reg),
        .rate_step     (step_reg),
        .accel_end     (accel_reg),
        .decel_start   (decel_reg),
        .steps_done    (in_data_reg[OFS_STEPS +: STEP_BITS]),
        .axis_moving   (in_data_reg[OFS_MOVING]),
        .pause_flag    (in_data_reg[OFS_PAUSE]),
        .flush_flag    (in_data_reg[OFS_FLUSH]),
        .min_rate      (min_rate_reg),
        .next_rate     (upd_rate),
        .rate_out      (upd_rate_out),
        .ctl           (upd_ctl)
    );

    // next state and result per command
    always_comb begin
        loaded_next   = loaded_reg;
        force_next    = force_reg;
        rate_next     = rate_reg;
        out_rate_next = '0;
        out_flag_next = 1'b0;
        out_stop_next = 1'b0;
        case (in_cmd_reg)
            CMD_LOAD: begin
                loaded_next = 1'b1;
                force_next  = 1'b1;
                rate_next   = in_data_reg[OFS_START +: RATE_BITS];
            end
            CMD_END: begin
                loaded_next = 1'b0;
            end
            CMD_TICK: begin
                if (upd_ctl.active) begin
                    force_next    = 1'b0;
                    rate_next     = upd_rate;
                    out_rate_next = upd_rate_out;
                    out_flag_next = upd_ctl.valid;
                    out_stop_next = upd_ctl.stop;
                end
            end
            default: begin
                loaded_next = loaded_reg;
            end
        endcase
    end

    // move state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
            force_reg  <= 1'b0;
        end else if (advance) begin
            loaded_reg <= loaded_next;
            force_reg  <= force_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rate_reg <= rate_next;
            if (in_cmd_reg == CMD_LOAD) begin
                cruise_reg <= in_data_reg[OFS_CRUISE +: RATE_BITS];
                end_reg    <= in_data_reg[OFS_END +: RATE_BITS];
                step_reg   <= in_data_reg[OFS_STEP +: RATE_BITS];
                accel_reg  <= in_data_reg[OFS_ACCEL +: STEP_BITS];
                decel_reg  <= in_data_reg[OFS_DECEL +: STEP_BITS];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rate_reg <= out_rate_next;
            out_flag_reg <= out_flag_next;
            out_stop_reg <= out_stop_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS-RATE_BITS-2){1'b0}},
                       out_stop_reg, out_flag_reg, out_rate_reg};

    // checks
    a_valid_stop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_flag_reg && out_stop_reg))
        else $error("rate update and stop issued together");

    a_rate_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_flag_reg) |-> (out_rate_reg == '0))
        else $error("rate nonzero without rate update");

    a_rate_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_flag_next) |=> (out_rate_reg >= $past(min_rate_reg)))
        else $error("issued rate below min_rate");

    a_load_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_LOAD) |=> (loaded_reg && force_reg))
        else $error("load did not arm the move");

    a_no_tick_unloaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !loaded_reg) |=> !(out_flag_reg || out_stop_reg))
        else $error("tick result while no move loaded");

endmodule
